/* hw/rtl/grid_agent_usage_counter_unit_macros.svh */
// assertion macros shared by the grid agent usage counter rtl
// plain text macros, no other dependencies

`ifndef GRID_AGENT_USAGE_COUNTER_UNIT_MACROS_SVH
`define GRID_AGENT_USAGE_COUNTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GAUC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GAUC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/gauc_pkg.sv */
// types, codes and fixed widths of the grid agent usage counter
// no dependencies

package gauc_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 6;
    localparam int HDG_W      = 2;
    localparam int ACT_W      = 2;
    localparam int CI_W       = 12;
    localparam int STATUS_W   = 2;
    localparam int OUT_W      = 32;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    // compare width for coordinates against the grid size
    localparam int CMP_W      = 8;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // op codes
    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_ACTION = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // actions
    localparam logic [ACT_W-1:0] ACT_FWD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_WAIT  = 2'd3;

    // headings
    localparam logic [HDG_W-1:0] HDG_EAST  = 2'd0;
    localparam logic [HDG_W-1:0] HDG_SOUTH = 2'd1;
    localparam logic [HDG_W-1:0] HDG_WEST  = 2'd2;
    localparam logic [HDG_W-1:0] HDG_NORTH = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MOVE_REJ  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_START_REJ = 2'd2;

    // counter fields inside one memory word, low field first
    localparam int NUM_FIELDS = 6;
    localparam int FLD_VISIT  = 0;
    localparam int FLD_WAIT   = 1;
    localparam int FLD_RIGHT  = 2;
    localparam int FLD_UP     = 3;
    localparam int FLD_LEFT   = 4;
    localparam int FLD_DOWN   = 5;

    // direction slots, offset from FLD_RIGHT
    localparam logic [1:0] SLOT_RIGHT = 2'd0;
    localparam logic [1:0] SLOT_UP    = 2'd1;
    localparam logic [1:0] SLOT_LEFT  = 2'd2;
    localparam logic [1:0] SLOT_DOWN  = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_WR_A,
        ST_RD_B,
        ST_WR_B
    } state_t;

    // what one item does to the counter memory
    typedef struct packed {
        logic                dir_bump;
        logic [1:0]          dir_slot;
        logic                visit_bump;
        logic                wait_bump;
        logic                report_valid;
        logic                pose_load;
        logic [STATUS_W-1:0] status;
    } plan_t;

    function automatic logic [1:0] dir_slot_of(input logic [HDG_W-1:0] hdg);
        logic [1:0] slot;
        case (hdg)
            HDG_EAST:  slot = SLOT_RIGHT;
            HDG_SOUTH: slot = SLOT_DOWN;
            HDG_WEST:  slot = SLOT_LEFT;
            default:   slot = SLOT_UP;
        endcase
        return slot;
    endfunction

endpackage

/* hw/rtl/gauc_in_if.sv */
// input item channel of the grid agent usage counter
// depends on gauc_pkg

interface gauc_in_if;
    logic                          valid;
    logic                          ready;
    logic [gauc_pkg::OP_W-1:0]     op;
    logic [gauc_pkg::COORD_W-1:0]  start_x;
    logic [gauc_pkg::COORD_W-1:0]  start_y;
    logic [gauc_pkg::HDG_W-1:0]    start_heading;
    logic [gauc_pkg::ACT_W-1:0]    action;
    logic [gauc_pkg::CI_W-1:0]     cell_index;

    modport source (
        output valid, op, start_x, start_y, start_heading, action, cell_index,
        input  ready
    );
    modport sink (
        input  valid, op, start_x, start_y, start_heading, action, cell_index,
        output ready
    );
endinterface

/* hw/rtl/gauc_out_if.sv */
// result channel of the grid agent usage counter
// depends on gauc_pkg

interface gauc_out_if;
    logic                           valid;
    logic                           ready;
    logic [gauc_pkg::STATUS_W-1:0]  status;
    logic [gauc_pkg::COORD_W-1:0]   pos_x;
    logic [gauc_pkg::COORD_W-1:0]   pos_y;
    logic [gauc_pkg::HDG_W-1:0]     heading;
    logic [gauc_pkg::OUT_W-1:0]     visit_count;
    logic [gauc_pkg::OUT_W-1:0]     wait_total;
    logic [gauc_pkg::OUT_W-1:0]     moves_right;
    logic [gauc_pkg::OUT_W-1:0]     moves_up;
    logic [gauc_pkg::OUT_W-1:0]     moves_left;
    logic [gauc_pkg::OUT_W-1:0]     moves_down;

    modport source (
        output valid, status, pos_x, pos_y, heading, visit_count, wait_total,
               moves_right, moves_up, moves_left, moves_down,
        input  ready
    );
    modport sink (
        input  valid, status, pos_x, pos_y, heading, visit_count, wait_total,
               moves_right, moves_up, moves_left, moves_down,
        output ready
    );
endinterface

/* hw/rtl/gauc_cfg_if.sv */
// configuration write channel of the grid agent usage counter
// depends on gauc_pkg

interface gauc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gauc_pkg::CFG_IDX_W-1:0]  index;
    logic [gauc_pkg::CFG_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* hw/rtl/gauc_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies

module gauc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/gauc_plan.sv */
// decodes one item against the agent pose and grid size into a memory plan
// depends on gauc_pkg

module gauc_plan #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    localparam int X_W     = $clog2(MAX_COLS),
    localparam int Y_W     = $clog2(MAX_ROWS),
    localparam int ADDR_W  = $clog2(MAX_COLS * MAX_ROWS)
) (
    input  logic [gauc_pkg::CFG_W-1:0]   grid_width,
    input  logic [gauc_pkg::CFG_W-1:0]   grid_height,
    input  logic [X_W-1:0]               agent_x,
    input  logic [Y_W-1:0]               agent_y,
    input  logic [gauc_pkg::HDG_W-1:0]   agent_heading,
    input  logic [gauc_pkg::OP_W-1:0]    op,
    input  logic [gauc_pkg::COORD_W-1:0] start_x,
    input  logic [gauc_pkg::COORD_W-1:0] start_y,
    input  logic [gauc_pkg::HDG_W-1:0]   start_heading,
    input  logic [gauc_pkg::ACT_W-1:0]   action,
    input  logic [gauc_pkg::CI_W-1:0]    cell_index,
    output gauc_pkg::plan_t              plan,
    output logic [ADDR_W-1:0]            addr_a,
    output logic [ADDR_W-1:0]            addr_b,
    output logic [X_W-1:0]               new_x,
    output logic [Y_W-1:0]               new_y,
    output logic [gauc_pkg::HDG_W-1:0]   new_heading
);

    localparam int CELL_W = Y_W + gauc_pkg::CFG_W + 1;
    localparam int AREA_W = 2 * gauc_pkg::CFG_W;
    localparam int CW     = gauc_pkg::CMP_W;

    logic [gauc_pkg::CFG_W-1:0] eff_w;
    logic [gauc_pkg::CFG_W-1:0] eff_h;
    logic [CW-1:0]              ax_c;
    logic [CW-1:0]              ay_c;
    logic [CW-1:0]              ew_c;
    logic [CW-1:0]              eh_c;
    logic                       agent_in;
    logic                       start_in;
    logic                       ci_in;
    logic [CELL_W-1:0]          agent_cell;
    logic [CELL_W-1:0]          start_cell;
    logic [CELL_W-1:0]          fwd_cell;
    logic [CELL_W-1:0]          report_cell;
    logic [AREA_W-1:0]          area;
    logic                       fwd_ok;
    logic [X_W-1:0]             fwd_x;
    logic [Y_W-1:0]             fwd_y;

    // out-of-range sizes clamp to 1 and to the maximum
    always_comb
    begin
        if (grid_width == '0)
            eff_w = gauc_pkg::CFG_W'(1);
        else if (int'(grid_width) > MAX_COLS)
            eff_w = gauc_pkg::CFG_W'(MAX_COLS);
        else
            eff_w = grid_width;

        if (grid_height == '0)
            eff_h = gauc_pkg::CFG_W'(1);
        else if (int'(grid_height) > MAX_ROWS)
            eff_h = gauc_pkg::CFG_W'(MAX_ROWS);
        else
            eff_h = grid_height;
    end

    assign ax_c = CW'(agent_x);
    assign ay_c = CW'(agent_y);
    assign ew_c = CW'(eff_w);
    assign eh_c = CW'(eff_h);

    assign agent_in = (ax_c < ew_c) && (ay_c < eh_c);
    assign start_in = (CW'(start_x) < ew_c) && (CW'(start_y) < eh_c);

    assign agent_cell = CELL_W'(agent_y) * CELL_W'(eff_w) + CELL_W'(agent_x);
    assign start_cell = CELL_W'(start_y) * CELL_W'(eff_w) + CELL_W'(start_x);
    assign area       = AREA_W'(eff_w) * AREA_W'(eff_h);
    assign ci_in      = AREA_W'(cell_index) < area;

    // neighbor cell along the heading
    always_comb
    begin
        fwd_x = agent_x;
        fwd_y = agent_y;
        case (agent_heading)
            gauc_pkg::HDG_EAST:
            begin
                fwd_ok   = (ax_c + CW'(1)) < ew_c;
                fwd_cell = agent_cell + CELL_W'(1);
                fwd_x    = agent_x + X_W'(1);
            end
            gauc_pkg::HDG_SOUTH:
            begin
                fwd_ok   = (ay_c + CW'(1)) < eh_c;
                fwd_cell = agent_cell + CELL_W'(eff_w);
                fwd_y    = agent_y + Y_W'(1);
            end
            gauc_pkg::HDG_WEST:
            begin
                fwd_ok   = agent_x != '0;
                fwd_cell = agent_cell - CELL_W'(1);
                fwd_x    = agent_x - X_W'(1);
            end
            default:
            begin
                fwd_ok   = agent_y != '0;
                fwd_cell = agent_cell - CELL_W'(eff_w);
                fwd_y    = agent_y - Y_W'(1);
            end
        endcase
    end

    always_comb
    begin
        plan              = '0;
        plan.status       = gauc_pkg::STATUS_OK;
        plan.report_valid = agent_in;
        report_cell       = agent_cell;
        new_x             = agent_x;
        new_y             = agent_y;
        new_heading       = agent_heading;
        case (op)
            gauc_pkg::OP_START:
            begin
                if (start_in)
                begin
                    plan.pose_load    = 1'b1;
                    plan.visit_bump   = 1'b1;
                    plan.report_valid = 1'b1;
                    report_cell       = start_cell;
                    new_x             = X_W'(start_x);
                    new_y             = Y_W'(start_y);
                    new_heading       = start_heading;
                end
                else
                begin
                    plan.status = gauc_pkg::STATUS_START_REJ;
                end
            end
            gauc_pkg::OP_ACTION:
            begin
                if (!agent_in)
                begin
                    plan.status = gauc_pkg::STATUS_MOVE_REJ;
                end
                else
                begin
                    case (action)
                        gauc_pkg::ACT_FWD:
                        begin
                            if (fwd_ok)
                            begin
                                plan.pose_load  = 1'b1;
                                plan.visit_bump = 1'b1;
                                plan.dir_bump   = 1'b1;
                                plan.dir_slot   = gauc_pkg::dir_slot_of(agent_heading);
                                report_cell     = fwd_cell;
                                new_x           = fwd_x;
                                new_y           = fwd_y;
                            end
                            else
                            begin
                                plan.status = gauc_pkg::STATUS_MOVE_REJ;
                            end
                        end
                        gauc_pkg::ACT_RIGHT:
                        begin
                            plan.pose_load  = 1'b1;
                            plan.visit_bump = 1'b1;
                            new_heading     = agent_heading + gauc_pkg::HDG_W'(1);
                        end
                        gauc_pkg::ACT_LEFT:
                        begin
                            plan.pose_load  = 1'b1;
                            plan.visit_bump = 1'b1;
                            new_heading     = agent_heading + gauc_pkg::HDG_W'(3);
                        end
                        default:
                        begin
                            plan.pose_load  = 1'b1;
                            plan.visit_bump = 1'b1;
                            plan.wait_bump  = 1'b1;
                        end
                    endcase
                end
            end
            gauc_pkg::OP_READ:
            begin
                plan.report_valid = ci_in;
                report_cell       = CELL_W'(cell_index);
            end
            default:
            begin
            end
        endcase
    end

    assign addr_a = ADDR_W'(agent_cell);
    // a cell that reads as zero still gets a legal address
    assign addr_b = plan.report_valid ? ADDR_W'(report_cell) : '0;

endmodule

/* hw/rtl/grid_agent_usage_counter_unit.sv */
// channel    | dir | payload                                         | word accepted when
// items      | in  | op, start pose, action, cell_index              | items.valid & items.ready
// results    | out | status, pose, six cell counters                 | results.valid & results.ready
// cfg        | in  | index, data (grid_width, grid_height)           | cfg.valid & cfg.ready
//
// every item reads its cell through the single read port and writes it back through the
// write port if a visit is counted; an accepted forward move first does both for the cell left.
// after reset a clearing pass writes zero to all MAX_COLS*MAX_ROWS memory words, one a
// cycle (4096 words at the defaults); items wait for it, cfg writes are taken throughout.
// a result waits in the output register while the next item is accepted; a stalled result
// holds the final write step of the following item until it is taken.
// depends on gauc_pkg, the channel interfaces, gauc_plan, gauc_ram and the macro header

`include "grid_agent_usage_counter_unit_macros.svh"

module grid_agent_usage_counter_unit #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    gauc_in_if.sink    items,
    gauc_out_if.source results,
    gauc_cfg_if.sink   cfg
);

    localparam int X_W    = $clog2(MAX_COLS);
    localparam int Y_W    = $clog2(MAX_ROWS);
    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int NF     = gauc_pkg::NUM_FIELDS;
    localparam int WORD_W = NF * COUNT_BITS;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

    gauc_pkg::state_t             state_reg;
    gauc_pkg::state_t             state_next;
    logic [gauc_pkg::CFG_W-1:0]   grid_width_reg;
    logic [gauc_pkg::CFG_W-1:0]   grid_height_reg;
    logic [X_W-1:0]               agent_x_reg;
    logic [Y_W-1:0]               agent_y_reg;
    logic [gauc_pkg::HDG_W-1:0]   agent_heading_reg;
    logic [ADDR_W-1:0]            clr_reg;

    gauc_pkg::plan_t              plan_now;
    logic [ADDR_W-1:0]            addr_a_now;
    logic [ADDR_W-1:0]            addr_b_now;
    logic [X_W-1:0]               new_x;
    logic [Y_W-1:0]               new_y;
    logic [gauc_pkg::HDG_W-1:0]   new_heading;

    gauc_pkg::plan_t              plan_reg;
    logic [ADDR_W-1:0]            addr_a_reg;
    logic [ADDR_W-1:0]            addr_b_reg;

    logic                         in_ready;
    logic                         accept;
    logic                         out_free;
    logic                         out_load;
    logic                         out_valid_reg;
    logic [gauc_pkg::STATUS_W-1:0] status_reg;
    logic [gauc_pkg::OUT_W-1:0]   res_cnt_reg  [NF];
    logic [gauc_pkg::OUT_W-1:0]   res_cnt_next [NF];

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [WORD_W-1:0]            ram_wdata;
    logic                         ram_re;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [WORD_W-1:0]            ram_rdata;

    logic [COUNT_BITS-1:0]        rd_fld  [NF];
    logic [COUNT_BITS-1:0]        inc_fld [NF];
    logic [COUNT_BITS-1:0]        upd_b_fld [NF];
    logic [WORD_W-1:0]            wdata_a;
    logic [WORD_W-1:0]            wdata_b;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= gauc_pkg::GRID_RESET;
            grid_height_reg <= gauc_pkg::GRID_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                gauc_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg.data;
                gauc_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    gauc_plan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_plan (
        .grid_width    (grid_width_reg),
        .grid_height   (grid_height_reg),
        .agent_x       (agent_x_reg),
        .agent_y       (agent_y_reg),
        .agent_heading (agent_heading_reg),
        .op            (items.op),
        .start_x       (items.start_x),
        .start_y       (items.start_y),
        .start_heading (items.start_heading),
        .action        (items.action),
        .cell_index    (items.cell_index),
        .plan          (plan_now),
        .addr_a        (addr_a_now),
        .addr_b        (addr_b_now),
        .new_x         (new_x),
        .new_y         (new_y),
        .new_heading   (new_heading)
    );

    gauc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign items.ready = in_ready;
    assign accept      = items.valid && in_ready;
    assign out_free    = !out_valid_reg || results.ready;

    // counter updates on the word just read
    always_comb
    begin
        for (int i = 0; i < NF; i++)
        begin
            rd_fld[i]  = ram_rdata[i*COUNT_BITS +: COUNT_BITS];
            inc_fld[i] = (&rd_fld[i]) ? rd_fld[i] : rd_fld[i] + COUNT_BITS'(1);
            wdata_a[i*COUNT_BITS +: COUNT_BITS] =
                (i == gauc_pkg::FLD_RIGHT + int'(plan_reg.dir_slot)) ? inc_fld[i] : rd_fld[i];
            upd_b_fld[i] =
                ((i == gauc_pkg::FLD_VISIT) && plan_reg.visit_bump) ||
                ((i == gauc_pkg::FLD_WAIT) && plan_reg.wait_bump) ? inc_fld[i] : rd_fld[i];
            wdata_b[i*COUNT_BITS +: COUNT_BITS] = upd_b_fld[i];
            res_cnt_next[i] = plan_reg.report_valid ? gauc_pkg::OUT_W'(upd_b_fld[i]) : '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gauc_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                    state_next = gauc_pkg::ST_IDLE;
            end
            gauc_pkg::ST_IDLE:
            begin
                if (items.valid)
                    state_next = plan_now.dir_bump ? gauc_pkg::ST_RD_A : gauc_pkg::ST_RD_B;
            end
            gauc_pkg::ST_RD_A: state_next = gauc_pkg::ST_WR_A;
            gauc_pkg::ST_WR_A: state_next = gauc_pkg::ST_RD_B;
            gauc_pkg::ST_RD_B: state_next = gauc_pkg::ST_WR_B;
            gauc_pkg::ST_WR_B:
            begin
                if (out_free)
                    state_next = gauc_pkg::ST_IDLE;
            end
            default: state_next = gauc_pkg::ST_CLEAR;
        endcase
    end

    // memory port and handshake control
    always_comb
    begin
        in_ready  = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_b_reg;
        ram_wdata = wdata_b;
        ram_re    = 1'b0;
        ram_raddr = addr_b_reg;
        case (state_reg)
            gauc_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            gauc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            gauc_pkg::ST_RD_A:
            begin
                ram_re    = 1'b1;
                ram_raddr = addr_a_reg;
            end
            gauc_pkg::ST_WR_A:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_a_reg;
                ram_wdata = wdata_a;
            end
            gauc_pkg::ST_RD_B:
            begin
                ram_re = 1'b1;
            end
            gauc_pkg::ST_WR_B:
            begin
                out_load = out_free;
                ram_we   = out_free && plan_reg.visit_bump;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= gauc_pkg::ST_CLEAR;
            clr_reg           <= '0;
            agent_x_reg       <= '0;
            agent_y_reg       <= '0;
            agent_heading_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gauc_pkg::ST_CLEAR)
                clr_reg <= clr_reg + ADDR_W'(1);
            // pose moves at accept, the plan already holds the old cell
            if (accept && plan_now.pose_load)
            begin
                agent_x_reg       <= new_x;
                agent_y_reg       <= new_y;
                agent_heading_reg <= new_heading;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item plan and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plan_reg   <= plan_now;
            addr_a_reg <= addr_a_now;
            addr_b_reg <= addr_b_now;
        end
        if (out_load)
        begin
            status_reg  <= plan_reg.status;
            res_cnt_reg <= res_cnt_next;
            results.pos_x   <= gauc_pkg::COORD_W'(agent_x_reg);
            results.pos_y   <= gauc_pkg::COORD_W'(agent_y_reg);
            results.heading <= agent_heading_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = status_reg;
    assign results.visit_count = res_cnt_reg[gauc_pkg::FLD_VISIT];
    assign results.wait_total  = res_cnt_reg[gauc_pkg::FLD_WAIT];
    assign results.moves_right = res_cnt_reg[gauc_pkg::FLD_RIGHT];
    assign results.moves_up    = res_cnt_reg[gauc_pkg::FLD_UP];
    assign results.moves_left  = res_cnt_reg[gauc_pkg::FLD_LEFT];
    assign results.moves_down  = res_cnt_reg[gauc_pkg::FLD_DOWN];

    `GAUC_ASSERT_IMPL(a_result_after_wr_b, clk, rst_n, $rose(out_valid_reg), $past(state_reg == gauc_pkg::ST_WR_B), "result word appeared outside the final write step")
    `GAUC_ASSERT_IMPL(a_move_cells_differ, clk, rst_n, (state_reg == gauc_pkg::ST_RD_B) && plan_reg.dir_bump, addr_a_reg != addr_b_reg, "forward move leaves and enters the same cell")
    `GAUC_ASSERT_IMPL(a_bump_on_real_cell, clk, rst_n, (state_reg == gauc_pkg::ST_WR_B) && plan_reg.visit_bump, plan_reg.report_valid, "visit counted on a cell outside the grid")
    `GAUC_ASSERT_NEXT(a_stall_holds_write, clk, rst_n, (state_reg == gauc_pkg::ST_WR_B) && out_valid_reg && !results.ready, state_reg == gauc_pkg::ST_WR_B, "write-back left while the result word was stalled")

endmodule

/* verif/gauc_checker.sv */
// scoreboard for the grid agent usage counter: mirrors pose, grid size and cell counters,
// predicts one result word per accepted item word and compares it with the block's output
// depends on gauc_pkg and the item, result and cfg channel interfaces

module gauc_checker #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic clk,
    input  logic rst_n,
    gauc_in_if   items,
    gauc_out_if  results,
    gauc_cfg_if  cfg,
    output int   errors,
    output int   pending,
    output int   checked
);
    import gauc_pkg::*;

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam logic [OUT_W-1:0] COUNT_TOP = '1;
    // direction counter bumped by a forward move, indexed by heading
    localparam logic [1:0] SLOT_OF_HDG [4] = '{SLOT_RIGHT, SLOT_DOWN, SLOT_LEFT, SLOT_UP};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [HDG_W-1:0]    hdg;
        logic [OUT_W-1:0]    visits;
        logic [OUT_W-1:0]    waits;
        logic [OUT_W-1:0]    right;
        logic [OUT_W-1:0]    up;
        logic [OUT_W-1:0]    left;
        logic [OUT_W-1:0]    down;
    } cell_report_t;

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [COORD_W-1:0] agent_col;
    logic [COORD_W-1:0] agent_row;
    logic [HDG_W-1:0]   agent_hdg;
    logic [OUT_W-1:0]   visit_cnt [CELLS];
    logic [OUT_W-1:0]   wait_cnt  [CELLS];
    logic [OUT_W-1:0]   move_cnt  [CELLS][4];
    cell_report_t       expected_reports [$];

    initial errors = 0;

    function automatic int cols_in_use();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_COLS) return MAX_COLS;
        return int'(width_reg);
    endfunction

    function automatic int rows_in_use();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_ROWS) return MAX_ROWS;
        return int'(height_reg);
    endfunction

    function automatic bit on_grid(int col, int row);
        return col < cols_in_use() && row < rows_in_use();
    endfunction

    // CELLS when the agent sits outside the grid in use
    function automatic int agent_cell();
        if (!on_grid(agent_col, agent_row)) return CELLS;
        return int'(agent_row) * cols_in_use() + int'(agent_col);
    endfunction

    function automatic logic [OUT_W-1:0] sat_inc(logic [OUT_W-1:0] c);
        return (c == COUNT_TOP) ? c : c + OUT_W'(1);
    endfunction

    function automatic cell_report_t replay_item(
        logic [OP_W-1:0]    op,
        logic [COORD_W-1:0] sx,
        logic [COORD_W-1:0] sy,
        logic [HDG_W-1:0]   sh,
        logic [ACT_W-1:0]   act,
        logic [CI_W-1:0]    ci
    );
        cell_report_t     r;
        int               nx;
        int               ny;
        int               from;
        int               shown;
        logic [HDG_W-1:0] nh;
        bit               ok;
        r = '0;
        r.status = STATUS_OK;
        shown = -1;
        case (op)
            OP_START:
            begin
                if (on_grid(sx, sy))
                begin
                    agent_col = sx;
                    agent_row = sy;
                    agent_hdg = sh;
                    visit_cnt[agent_cell()] = sat_inc(visit_cnt[agent_cell()]);
                end
                else
                    r.status = STATUS_START_REJ;
            end
            OP_ACTION:
            begin
                if (!on_grid(agent_col, agent_row))
                    r.status = STATUS_MOVE_REJ;
                else
                begin
                    nx = agent_col;
                    ny = agent_row;
                    nh = agent_hdg;
                    ok = 1'b1;
                    from = agent_cell();
                    case (act)
                        ACT_FWD:
                        begin
                            case (agent_hdg)
                                HDG_EAST:
                                begin
                                    nx = int'(agent_col) + 1;
                                    ok = nx < cols_in_use();
                                end
                                HDG_SOUTH:
                                begin
                                    ny = int'(agent_row) + 1;
                                    ok = ny < rows_in_use();
                                end
                                HDG_WEST:
                                begin
                                    ok = agent_col != 0;
                                    nx = int'(agent_col) - 1;
                                end
                                default:
                                begin
                                    ok = agent_row != 0;
                                    ny = int'(agent_row) - 1;
                                end
                            endcase
                        end
                        ACT_RIGHT: nh = agent_hdg + 1'b1;
                        ACT_LEFT:  nh = agent_hdg - 1'b1;
                        default:   ;
                    endcase
                    if (!ok)
                        r.status = STATUS_MOVE_REJ;
                    else
                    begin
                        if (act == ACT_FWD)
                            move_cnt[from][SLOT_OF_HDG[agent_hdg]] =
                                sat_inc(move_cnt[from][SLOT_OF_HDG[agent_hdg]]);
                        else if (act == ACT_WAIT)
                            wait_cnt[from] = sat_inc(wait_cnt[from]);
                        agent_col = nx[COORD_W-1:0];
                        agent_row = ny[COORD_W-1:0];
                        agent_hdg = nh;
                        visit_cnt[agent_cell()] = sat_inc(visit_cnt[agent_cell()]);
                    end
                end
            end
            OP_READ: shown = int'(ci);
            default: ;
        endcase
        if (shown < 0)
            shown = agent_cell();
        r.x = agent_col;
        r.y = agent_row;
        r.hdg = agent_hdg;
        // a cell outside the grid in use reads as all zeros
        if (shown < cols_in_use() * rows_in_use())
        begin
            r.visits = visit_cnt[shown];
            r.waits = wait_cnt[shown];
            r.right = move_cnt[shown][SLOT_RIGHT];
            r.up = move_cnt[shown][SLOT_UP];
            r.left = move_cnt[shown][SLOT_LEFT];
            r.down = move_cnt[shown][SLOT_DOWN];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        if (errors < 40)
            $display("%0t: result %0d, %s: got %0d, expected %0d", $time, checked, what,
                     got, want);
        errors++;
    endtask

    task automatic compare_report(input cell_report_t got, input cell_report_t want);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.x !== want.x)           report_mismatch("pos_x", got.x, want.x);
        if (got.y !== want.y)           report_mismatch("pos_y", got.y, want.y);
        if (got.hdg !== want.hdg)       report_mismatch("heading", got.hdg, want.hdg);
        if (got.visits !== want.visits) report_mismatch("visit_count", got.visits, want.visits);
        if (got.waits !== want.waits)   report_mismatch("wait_total", got.waits, want.waits);
        if (got.right !== want.right)   report_mismatch("moves_right", got.right, want.right);
        if (got.up !== want.up)         report_mismatch("moves_up", got.up, want.up);
        if (got.left !== want.left)     report_mismatch("moves_left", got.left, want.left);
        if (got.down !== want.down)     report_mismatch("moves_down", got.down, want.down);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_report_t got;
        cell_report_t predicted;
        if (!rst_n)
        begin
            width_reg = GRID_RESET;
            height_reg = GRID_RESET;
            agent_col = '0;
            agent_row = '0;
            agent_hdg = HDG_EAST;
            for (int i = 0; i < CELLS; i++)
            begin
                visit_cnt[i] = '0;
                wait_cnt[i] = '0;
                for (int k = 0; k < 4; k++)
                    move_cnt[i][k] = '0;
            end
            expected_reports.delete();
            checked = 0;
            pending <= 0;
        end
        else
        begin
            // results first: a word taken now belongs to an item accepted earlier
            if (results.valid && results.ready)
            begin
                got.status = results.status;
                got.x = results.pos_x;
                got.y = results.pos_y;
                got.hdg = results.heading;
                got.visits = results.visit_count;
                got.waits = results.wait_total;
                got.right = results.moves_right;
                got.up = results.moves_up;
                got.left = results.moves_left;
                got.down = results.moves_down;
                if (expected_reports.size() == 0)
                    report_mismatch("unexpected result word", '0, '0);
                else
                    compare_report(got, expected_reports.pop_front());
                checked++;
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_GRID_WIDTH)
                    width_reg = cfg.data;
                else if (cfg.index == REG_GRID_HEIGHT)
                    height_reg = cfg.data;
            end
            if (items.valid && items.ready)
            begin
                predicted = replay_item(items.op, items.start_x, items.start_y,
                    items.start_heading, items.action, items.cell_index);
                expected_reports = {expected_reports, predicted};
            end
            pending <= expected_reports.size();
        end
    end

endmodule

/* verif/tb.sv */
// top of the grid agent usage counter testbench: clock, reset, item and cfg stimulus,
// result back-pressure and the verdict; prediction and comparison sit in gauc_checker
// depends on gauc_pkg, the channel interfaces, gauc_checker and the block itself

module tb;
    import gauc_pkg::*;

    localparam int GRID_MAX = 64;
    localparam int LIMIT_TIME = 2_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 400;
    localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   in_flight;
    int   results_checked;
    int   send_gap_pct;
    int   take_gap_pct;
    int   hold_requests;
    int   holds_served;
    int   hold_left;
    int   cols;
    int   rows;
    int   grids_used;
    int   n_start;
    int   n_action;
    int   n_read;
    int   n_unused;

    gauc_in_if  items_if ();
    gauc_out_if results_if ();
    gauc_cfg_if cfg_if ();

    grid_agent_usage_counter_unit #(
        .MAX_COLS (GRID_MAX),
        .MAX_ROWS (GRID_MAX)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    gauc_checker #(
        .MAX_COLS (GRID_MAX),
        .MAX_ROWS (GRID_MAX)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if),
        .cfg     (cfg_if),
        .errors  (mismatches),
        .pending (in_flight),
        .checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_TIME);
        $display("timeout: run did not finish, %0d results outstanding", in_flight);
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        results_if.ready <= 1'b0;
        holds_served = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
                results_if.ready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    function automatic int dim_in_use(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > GRID_MAX) return GRID_MAX;
        return int'(v);
    endfunction

    task automatic send_item(
        input logic [OP_W-1:0]    op,
        input logic [COORD_W-1:0] sx,
        input logic [COORD_W-1:0] sy,
        input logic [HDG_W-1:0]   sh,
        input logic [ACT_W-1:0]   act,
        input logic [CI_W-1:0]    ci
    );
        while ($urandom_range(99) < send_gap_pct)
        begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.op <= op;
        items_if.start_x <= sx;
        items_if.start_y <= sy;
        items_if.start_heading <= sh;
        items_if.action <= act;
        items_if.cell_index <= ci;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        case (op)
            OP_START:  n_start++;
            OP_ACTION: n_action++;
            OP_READ:   n_read++;
            default:   n_unused++;
        endcase
    endtask

    task automatic end_burst();
        items_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        while (in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        cols = dim_in_use(w);
        rows = dim_in_use(h);
        grids_used++;
    endtask

    // mostly well-formed traffic: starts inside the grid, many forward moves, reads of
    // cells in use; the rest is random fields, off-grid starts and stray indexes
    task automatic run_random(input int count);
        int                 done;
        int                 pick;
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [HDG_W-1:0]   sh;
        logic [ACT_W-1:0]   act;
        logic [CI_W-1:0]    ci;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            sx = COORD_W'($urandom);
            sy = COORD_W'($urandom);
            sh = HDG_W'($urandom);
            act = ACT_W'($urandom);
            ci = CI_W'($urandom);
            if (pick < 10)
            begin
                op = OP_START;
                if ($urandom_range(5) != 0)
                begin
                    sx = COORD_W'($urandom_range(cols - 1));
                    sy = COORD_W'($urandom_range(rows - 1));
                end
            end
            else if (pick < 80)
            begin
                op = OP_ACTION;
                if ($urandom_range(99) < 45)
                    act = ACT_FWD;
            end
            else if (pick < 97)
            begin
                op = OP_READ;
                if ($urandom_range(3) != 0)
                    ci = CI_W'($urandom_range(cols * rows - 1));
            end
            else
                op = OP_UNUSED;
            send_item(op, sx, sy, sh, act, ci);
            if (op != OP_UNUSED)
                done++;
        end
        end_burst();
    endtask

    initial
    begin
        rst_n = 1'b0;
        items_if.valid <= 1'b0;
        items_if.op <= OP_START;
        items_if.start_x <= '0;
        items_if.start_y <= '0;
        items_if.start_heading <= HDG_EAST;
        items_if.action <= ACT_FWD;
        items_if.cell_index <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_GRID_WIDTH;
        cfg_if.data <= '0;
        send_gap_pct = 30;
        take_gap_pct = 86;
        hold_requests = 0;
        cols = GRID_MAX;
        rows = GRID_MAX;
        grids_used = 0;
        n_start = 0;
        n_action = 0;
        n_read = 0;
        n_unused = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unmapped indexes must be ignored
        write_reg(REG_UNMAPPED_LO, CFG_W'($urandom));
        write_reg(REG_UNMAPPED_HI, CFG_W'($urandom));
        set_grid(7'd64, 7'd64);

        send_item(OP_READ, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_UNUSED, 6'd63, 6'd63, HDG_NORTH, ACT_WAIT, 12'hfff);
        send_item(OP_START, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_RIGHT, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_LEFT, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_WAIT, '0);
        // corner cell: east and south edges block, west and north moves pass
        send_item(OP_START, 6'd63, 6'd63, HDG_EAST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_RIGHT, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_RIGHT, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_RIGHT, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_FWD, '0);
        // origin: west and north edges block
        send_item(OP_START, '0, '0, HDG_WEST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_RIGHT, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_READ, '0, '0, HDG_EAST, ACT_FWD, 12'd4095);
        send_item(OP_START, 6'd50, 6'd50, HDG_SOUTH, ACT_FWD, '0);
        end_burst();

        // shrink under the agent, then off-grid starts and reads past the grid in use
        set_grid(7'd10, 7'd7);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_WAIT, '0);
        send_item(OP_START, 6'd40, 6'd3, HDG_EAST, ACT_FWD, '0);
        send_item(OP_START, 6'd3, 6'd40, HDG_EAST, ACT_FWD, '0);
        send_item(OP_START, 6'd9, 6'd6, HDG_EAST, ACT_FWD, '0);
        send_item(OP_ACTION, '0, '0, HDG_EAST, ACT_FWD, '0);
        send_item(OP_READ, '0, '0, HDG_EAST, ACT_FWD, 12'd69);
        send_item(OP_READ, '0, '0, HDG_EAST, ACT_FWD, 12'd70);
        end_burst();

        run_random(100);
        set_grid(7'd64, 7'd64);
        run_random(200);
        set_grid(7'd1, 7'd1);
        run_random(100);

        send_gap_pct = 86;
        take_gap_pct = 30;
        set_grid(7'd0, 7'd127);
        run_random(150);
        set_grid(7'd127, 7'd0);
        run_random(150);
        set_grid(CFG_W'($urandom_range(2, 63)), CFG_W'($urandom_range(2, 63)));
        run_random(200);

        send_gap_pct = 0;
        take_gap_pct = 0;
        set_grid(7'd64, 7'd64);
        // long result stall while items keep coming, so the block backs up its input
        hold_requests++;
        run_random(200);
        set_grid(7'd5, 7'd3);
        run_random(150);

        settle();
        $display("covered %0d starts, %0d actions, %0d reads, %0d unused op words on %0d grids",
                 n_start, n_action, n_read, n_unused, grids_used);
        $display("%0d result words compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/gauc_pkg.sv
hw/rtl/gauc_in_if.sv
hw/rtl/gauc_out_if.sv
hw/rtl/gauc_cfg_if.sv
hw/rtl/gauc_ram.sv
hw/rtl/gauc_plan.sv
hw/rtl/grid_agent_usage_counter_unit.sv
verif/gauc_checker.sv
verif/tb.sv
